@@ rtl/wav_header_parser_top_defines.svh @@
// Assertion macros shared by the WAV header parser RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef WAV_HEADER_PARSER_TOP_DEFINES_SVH
`define WAV_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Plain check that holds at every clock edge outside reset.
`define WAVHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Same-cycle implication.
`define WAVHP_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication.
`define WAVHP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define WAVHP_ASSERT(label, prop, msg)
`define WAVHP_ASSERT_IMP(label, pre, post, msg)
`define WAVHP_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

@@ rtl/wavhp_pkg.sv @@
// Types, codes and constants of the WAV header parser.
// No dependencies; used by the channel interfaces, the core and the top level.
package wavhp_pkg;

    // Chunk identifiers, first byte in the low bits as they arrive on the stream.
    localparam logic [31:0] FCC_WAVE = 32'h45564157;
    localparam logic [31:0] FCC_FMT  = 32'h20746D66;
    localparam logic [31:0] FCC_DATA = 32'h61746164;
    localparam logic [31:0] FCC_DISP = 32'h50534944;
    localparam logic [31:0] FCC_LIST = 32'h5453494C;
    localparam logic [31:0] FCC_FACT = 32'h74636166;

    // Byte positions inside the headers.
    localparam logic [31:0] POS_FORM_ID   = 32'd8;
    localparam logic [31:0] POS_HDR_LAST  = 32'd11;
    localparam logic [31:0] POS_SIZE_FRST = 32'd4;
    localparam logic [31:0] POS_CHDR_LAST = 32'd7;
    localparam logic [31:0] POS_FMT_TAG   = 32'd0;
    localparam logic [31:0] POS_FMT_CHAN  = 32'd2;
    localparam logic [31:0] POS_FMT_RATE0 = 32'd4;
    localparam logic [31:0] POS_FMT_RATE3 = 32'd7;
    localparam logic [31:0] POS_FMT_BITS  = 32'd14;

    localparam logic [31:0] FMT_MIN_SIZE  = 32'd16;
    localparam logic [7:0]  FMT_TAG_PCM   = 8'd1;

    // Configuration register reset values.
    localparam logic [31:0] RST_RATE     = 32'd8000;
    localparam logic [7:0]  RST_BITS     = 8'd8;
    localparam logic [7:0]  RST_CHANNELS = 8'd1;
    localparam logic [31:0] RST_MIN_DATA = 32'd1024;
    localparam logic [7:0]  RST_MAX_FMT  = 8'd100;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQ_RATE     = 3'd0,
        CFG_REQ_BITS     = 3'd1,
        CFG_REQ_CHANNELS = 3'd2,
        CFG_MIN_DATA     = 3'd3,
        CFG_MAX_FMT      = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_INVALID  = 2'd0,
        ST_BAD_RATE = 2'd1,
        ST_READY    = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_CHUNK  = 5'b00010,
        PH_FMT    = 5'b00100,
        PH_SKIP   = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    // Configuration register file as seen by the core.
    typedef struct packed {
        logic [31:0] req_rate;
        logic [7:0]  req_bits;
        logic [7:0]  req_channels;
        logic [31:0] min_data;
        logic [7:0]  max_fmt;
    } t_cfg;

    // Result of one processed byte.
    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [31:0] data_size;
    } t_result;

endpackage

@@ rtl/wavhp_channels.sv @@
// Valid/ready channel interfaces of the WAV header parser: input bytes,
// results and configuration writes. Depends on wavhp_pkg.
interface wavhp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface wavhp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] data_size;

    modport source (output valid, output status, output data_size, input ready);
    modport sink   (input valid, input status, input data_size, output ready);
endinterface

interface wavhp_cfg_if;
    import wavhp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/wav_header_parser_top.sv @@
// Top level of the WAV header parser: input register, configuration registers,
// parser core and result register. Depends on wavhp_pkg, the channel interfaces,
// wavhp_core and the assertion macros.
//
//  Channel    Modport  Payload                       Transfer
//  i_in_ch    sink     data_byte[7:0], stream_end    valid && ready
//  o_out_ch   source   status[1:0], data_size[31:0]  valid && ready
//  i_cfg_ch   sink     index[2:0], data[31:0]        valid && ready (ready is always high)
//
// One byte is taken per cycle while the result channel is not stalled; a byte is held in the
// input register, and its result is then written into the result register, from which it leaves.
// i_rst_n is synchronous and active low; it restores the register reset values and
// puts the parser at the start of the RIFF header. A stalled result holds the result
// register, and the input register then holds one byte before i_in_ch.ready drops.
`include "wav_header_parser_top_defines.svh"

module wav_header_parser_top (
    input logic      i_clk,
    input logic      i_rst_n,
    wavhp_in_if.sink   i_in_ch,
    wavhp_out_if.source o_out_ch,
    wavhp_cfg_if.sink  i_cfg_ch
);
    import wavhp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_end;
    logic       r_out_valid;
    logic [1:0] r_out_status;
    logic [31:0] r_out_size;
    t_cfg       r_cfg;
    t_result    core_res;
    logic       step;

    // The core steps when the result register is free or is being emptied.
    assign step           = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready  = !r_in_valid || step;
    assign i_cfg_ch.ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_byte <= i_in_ch.data_byte;
            r_in_end  <= i_in_ch.stream_end;
        end
    end

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{req_rate: RST_RATE, req_bits: RST_BITS, req_channels: RST_CHANNELS,
                       min_data: RST_MIN_DATA, max_fmt: RST_MAX_FMT};
        end else if (i_cfg_ch.valid && i_cfg_ch.ready) begin
            case (i_cfg_ch.index)
                CFG_REQ_RATE:     r_cfg.req_rate     <= i_cfg_ch.data;
                CFG_REQ_BITS:     r_cfg.req_bits     <= i_cfg_ch.data[7:0];
                CFG_REQ_CHANNELS: r_cfg.req_channels <= i_cfg_ch.data[7:0];
                CFG_MIN_DATA:     r_cfg.min_data     <= i_cfg_ch.data;
                CFG_MAX_FMT:      r_cfg.max_fmt      <= i_cfg_ch.data[7:0];
                default: begin
                end
            endcase
        end
    end

    wavhp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .i_cfg   (r_cfg),
        .o_res   (core_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= core_res.valid;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && core_res.valid) begin
            r_out_status <= core_res.status;
            r_out_size   <= core_res.data_size;
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.status    = r_out_status;
    assign o_out_ch.data_size = r_out_size;

    // Input backpressure only comes from a held byte.
    `WAVHP_ASSERT_IMP(a_in_stall, !i_in_ch.ready, r_in_valid && r_out_valid,
        "input stalled without a held byte and a pending result")
    // Only the three defined status codes leave the block.
    `WAVHP_ASSERT_IMP(a_status_code, o_out_ch.valid,
        o_out_ch.status == ST_INVALID || o_out_ch.status == ST_BAD_RATE
        || o_out_ch.status == ST_READY,
        "undefined status code on the result channel")
    // A data size is carried only with the ready status.
    `WAVHP_ASSERT_IMP(a_size_zero, o_out_ch.valid && o_out_ch.status != ST_READY,
        o_out_ch.data_size == 32'd0,
        "nonzero data size with a failing status")

endmodule

@@ rtl/wavhp_core.sv @@
// Parser state machine: phase, byte counter, chunk id and size, fmt fields.
// One byte is processed per step. Depends on wavhp_pkg and the assertion macros.
`include "wav_header_parser_top_defines.svh"

module wavhp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  logic              i_end,
    input  wavhp_pkg::t_cfg   i_cfg,
    output wavhp_pkg::t_result o_res
);
    import wavhp_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [31:0] r_count,    n_count;
    logic [31:0] r_id,       n_id;
    logic [31:0] r_size,     n_size;
    logic [7:0]  r_fmt_tag,  n_fmt_tag;
    logic [7:0]  r_chan,     n_chan;
    logic [7:0]  r_bits,     n_bits;
    logic [31:0] r_rate,     n_rate;

    logic [31:0] count_inc;
    logic [31:0] id_shift;
    logic [31:0] size_shift;
    logic [31:0] size_pad;

    // Little-endian shift registers and even padding of the new size.
    assign count_inc  = r_count + 32'd1;
    assign id_shift   = {i_byte, r_id[31:8]};
    assign size_shift = {i_byte, r_size[31:8]};
    assign size_pad   = size_shift + {31'd0, size_shift[0]};

    // Next-state and result logic for one byte.
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_id      = r_id;
        n_size    = r_size;
        n_fmt_tag = r_fmt_tag;
        n_chan    = r_chan;
        n_bits    = r_bits;
        n_rate    = r_rate;
        o_res     = '{valid: 1'b0, status: ST_INVALID, data_size: 32'd0};

        if (i_step && i_end) begin
            // End of stream: back to the start; early end is reported as invalid.
            n_phase   = PH_HEADER;
            n_count   = 32'd0;
            n_id      = 32'd0;
            n_size    = 32'd0;
            n_fmt_tag = 8'd0;
            n_chan    = 8'd0;
            n_bits    = 8'd0;
            n_rate    = 32'd0;
            o_res.valid = (r_phase != PH_DONE);
        end else if (i_step) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_count >= POS_FORM_ID) begin
                        n_id = id_shift;
                    end
                    n_count = count_inc;
                    if (r_count == POS_HDR_LAST) begin
                        n_count = 32'd0;
                        if (id_shift != FCC_WAVE) begin
                            n_phase     = PH_DONE;
                            o_res.valid = 1'b1;
                        end else begin
                            n_phase = PH_CHUNK;
                        end
                    end
                end
                PH_CHUNK: begin
                    if (r_count < POS_SIZE_FRST) begin
                        n_id = id_shift;
                    end else begin
                        n_size = size_shift;
                    end
                    n_count = count_inc;
                    if (r_count == POS_CHDR_LAST) begin
                        n_count = 32'd0;
                        if (r_id == FCC_FMT) begin
                            n_size = size_pad;
                            if (size_pad > {24'd0, i_cfg.max_fmt} || size_pad < FMT_MIN_SIZE) begin
                                n_phase     = PH_DONE;
                                o_res.valid = 1'b1;
                            end else begin
                                n_phase = PH_FMT;
                            end
                        end else if (r_id == FCC_DATA) begin
                            n_phase     = PH_DONE;
                            o_res.valid = 1'b1;
                            if (size_shift >= i_cfg.min_data) begin
                                o_res.status    = ST_READY;
                                o_res.data_size = size_shift;
                            end
                        end else if (r_id == FCC_DISP || r_id == FCC_LIST || r_id == FCC_FACT) begin
                            n_size  = size_pad;
                            n_phase = (size_pad == 32'd0) ? PH_CHUNK : PH_SKIP;
                        end else begin
                            n_phase     = PH_DONE;
                            o_res.valid = 1'b1;
                        end
                    end
                end
                PH_FMT: begin
                    // Capture the fields of interest, then check them when the last byte arrives.
                    if (r_count == POS_FMT_TAG) begin
                        n_fmt_tag = i_byte;
                    end else if (r_count == POS_FMT_CHAN) begin
                        n_chan = i_byte;
                    end else if (r_count >= POS_FMT_RATE0 && r_count <= POS_FMT_RATE3) begin
                        n_rate = {i_byte, r_rate[31:8]};
                    end else if (r_count == POS_FMT_BITS) begin
                        n_bits = i_byte;
                    end
                    n_count = count_inc;
                    if (count_inc == r_size) begin
                        n_count = 32'd0;
                        if (n_fmt_tag != FMT_TAG_PCM || n_chan != i_cfg.req_channels
                                || n_bits != i_cfg.req_bits) begin
                            n_phase     = PH_DONE;
                            o_res.valid = 1'b1;
                        end else if (n_rate != i_cfg.req_rate) begin
                            n_phase      = PH_DONE;
                            o_res.valid  = 1'b1;
                            o_res.status = ST_BAD_RATE;
                        end else begin
                            n_phase = PH_CHUNK;
                        end
                    end
                end
                PH_SKIP: begin
                    n_count = count_inc;
                    if (count_inc == r_size) begin
                        n_count = 32'd0;
                        n_phase = PH_CHUNK;
                    end
                end
                PH_DONE: begin
                    // Bytes after a result are dropped.
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_count   <= 32'd0;
            r_id      <= 32'd0;
            r_size    <= 32'd0;
            r_fmt_tag <= 8'd0;
            r_chan    <= 8'd0;
            r_bits    <= 8'd0;
            r_rate    <= 32'd0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_id      <= n_id;
            r_size    <= n_size;
            r_fmt_tag <= n_fmt_tag;
            r_chan    <= n_chan;
            r_bits    <= n_bits;
            r_rate    <= n_rate;
        end
    end

    // The RIFF header phase never counts past its last byte.
    `WAVHP_ASSERT_IMP(a_header_count, r_phase == PH_HEADER, r_count <= POS_HDR_LAST,
        "header byte counter ran past the form id")
    // Inside a fmt body the counter stays below a legal padded size.
    `WAVHP_ASSERT_IMP(a_fmt_bounds, r_phase == PH_FMT,
        r_count < r_size && r_size >= FMT_MIN_SIZE && r_size[31:8] == 24'd0,
        "fmt body counter or size out of range")
    // A result from a data byte always leaves the parser in the done phase.
    `WAVHP_ASSERT_NEXT(a_result_done, i_step && !i_end && o_res.valid, r_phase == PH_DONE,
        "result given without entering the done phase")

endmodule

@@ tb/tb_wav_header_parser_top.sv @@
// Self-checking testbench for the WAV header parser top level.
// Streams generated RIFF WAV files into the block and compares every status with a built-in
// predictor. Depends on wavhp_pkg, the channel interfaces and wav_header_parser_top.
module tb_wav_header_parser_top;
    import wavhp_pkg::*;

    localparam int unsigned RANDOM_ITEMS      = 1100;
    localparam int unsigned SETTLE_CYCLES     = 8;
    localparam int unsigned DRAIN_LIMIT       = 20000;
    localparam int unsigned HOLD_CYCLES       = 400;
    localparam int unsigned FILES_PER_SETTING = 6;
    localparam int unsigned MAX_REPORTS       = 10;

    // Ways in which a generated fmt chunk departs from the current register settings.
    typedef enum int unsigned {
        FLAW_NONE,
        FLAW_SHORT,
        FLAW_LONG,
        FLAW_WRAP,
        FLAW_TAG,
        FLAW_CHANNELS,
        FLAW_BITS,
        FLAW_RATE
    } fmt_flaw_t;

    typedef struct {
        t_status     status;
        logic [31:0] data_size;
    } wav_verdict_t;

    // Header parser predictor and the queue of verdicts it still expects from the block.
    class wav_scoreboard;
        logic [31:0] req_rate;
        logic [7:0]  req_bits;
        logic [7:0]  req_channels;
        logic [31:0] min_data;
        logic [7:0]  max_fmt;

        t_phase      phase;
        logic [31:0] byte_pos;
        logic [31:0] chunk_id;
        logic [31:0] chunk_size;
        logic [7:0]  tag_low;
        logic [7:0]  chan_low;
        logic [7:0]  sample_bits;
        logic [31:0] sample_rate;

        wav_verdict_t pending[$];
        int unsigned  mismatches;
        int unsigned  verdicts;
        int unsigned  items_seen;

        function new();
            req_rate     = RST_RATE;
            req_bits     = RST_BITS;
            req_channels = RST_CHANNELS;
            min_data     = RST_MIN_DATA;
            max_fmt      = RST_MAX_FMT;
            mismatches   = 0;
            verdicts     = 0;
            items_seen   = 0;
            restart();
        endfunction

        function void restart();
            phase       = PH_HEADER;
            byte_pos    = '0;
            chunk_id    = '0;
            chunk_size  = '0;
            tag_low     = '0;
            chan_low    = '0;
            sample_bits = '0;
            sample_rate = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                CFG_REQ_RATE:     req_rate = value;
                CFG_REQ_BITS:     req_bits = value[7:0];
                CFG_REQ_CHANNELS: req_channels = value[7:0];
                CFG_MIN_DATA:     min_data = value;
                CFG_MAX_FMT:      max_fmt = value[7:0];
                default: ;
            endcase
        endfunction

        function void push_verdict(t_status st, logic [31:0] size);
            wav_verdict_t v;
            v.status    = st;
            v.data_size = size;
            pending.push_back(v);
            verdicts++;
        endfunction

        // A verdict ends parsing; later bytes are ignored until the stream ends.
        function void conclude(t_status st, logic [31:0] size);
            push_verdict(st, size);
            phase    = PH_DONE;
            byte_pos = '0;
        endfunction

        // Advances the predictor by one accepted input transfer.
        function void note_byte(logic [7:0] b, logic at_end);
            logic [31:0] pos;
            items_seen++;
            if (at_end) begin
                if (phase != PH_DONE) begin
                    push_verdict(ST_INVALID, '0);
                end
                restart();
                return;
            end
            pos = byte_pos;
            case (phase)
                PH_HEADER: begin
                    if (pos >= POS_FORM_ID) begin
                        chunk_id = {b, chunk_id[31:8]};
                    end
                    byte_pos = pos + 1;
                    if (pos == POS_HDR_LAST) begin
                        if (chunk_id != FCC_WAVE) begin
                            conclude(ST_INVALID, '0);
                        end else begin
                            phase    = PH_CHUNK;
                            byte_pos = '0;
                        end
                    end
                end
                PH_CHUNK: begin
                    if (pos < POS_SIZE_FRST) begin
                        chunk_id = {b, chunk_id[31:8]};
                    end else begin
                        chunk_size = {b, chunk_size[31:8]};
                    end
                    byte_pos = pos + 1;
                    if (pos == POS_CHDR_LAST) begin
                        byte_pos = '0;
                        if (chunk_id == FCC_FMT) begin
                            // Padding to even wraps in 32 bits.
                            chunk_size = chunk_size + 32'(chunk_size[0]);
                            if (chunk_size > 32'(max_fmt) || chunk_size < FMT_MIN_SIZE) begin
                                conclude(ST_INVALID, '0);
                            end else begin
                                phase = PH_FMT;
                            end
                        end else if (chunk_id == FCC_DATA) begin
                            if (chunk_size < min_data) begin
                                conclude(ST_INVALID, '0);
                            end else begin
                                conclude(ST_READY, chunk_size);
                            end
                        end else if (chunk_id == FCC_DISP || chunk_id == FCC_LIST ||
                                     chunk_id == FCC_FACT) begin
                            chunk_size = chunk_size + 32'(chunk_size[0]);
                            phase = (chunk_size == '0) ? PH_CHUNK : PH_SKIP;
                        end else begin
                            conclude(ST_INVALID, '0);
                        end
                    end
                end
                PH_FMT: begin
                    if (pos == POS_FMT_TAG) begin
                        tag_low = b;
                    end else if (pos == POS_FMT_CHAN) begin
                        chan_low = b;
                    end else if (pos >= POS_FMT_RATE0 && pos <= POS_FMT_RATE3) begin
                        sample_rate = {b, sample_rate[31:8]};
                    end else if (pos == POS_FMT_BITS) begin
                        sample_bits = b;
                    end
                    byte_pos = pos + 1;
                    if (byte_pos == chunk_size) begin
                        // Field checks in priority order, against the current registers.
                        byte_pos = '0;
                        if (tag_low != FMT_TAG_PCM) begin
                            conclude(ST_INVALID, '0);
                        end else if (chan_low != req_channels) begin
                            conclude(ST_INVALID, '0);
                        end else if (sample_bits != req_bits) begin
                            conclude(ST_INVALID, '0);
                        end else if (sample_rate != req_rate) begin
                            conclude(ST_BAD_RATE, '0);
                        end else begin
                            phase = PH_CHUNK;
                        end
                    end
                end
                PH_SKIP: begin
                    byte_pos = pos + 1;
                    if (byte_pos == chunk_size) begin
                        byte_pos = '0;
                        phase    = PH_CHUNK;
                    end
                end
                default: ;
            endcase
        endfunction

        // Compares one result transfer with the oldest expected verdict.
        function void check_result(logic [1:0] st, logic [31:0] size);
            wav_verdict_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: result with none expected: status %0d data_size %0d",
                             st, size);
                end
                return;
            end
            want = pending.pop_front();
            if (st !== want.status) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: status expected %0d got %0d", want.status, st);
                end
            end
            if (size !== want.data_size) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("ERROR: data_size expected %0d got %0d", want.data_size, size);
                end
            end
        endfunction

        function void flag_leftovers();
            if (pending.size() != 0) begin
                $display("ERROR: %0d expected results never arrived", pending.size());
                mismatches += pending.size();
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned rx_hold;
    int unsigned settings_used;

    wav_scoreboard sb = new();

    wavhp_in_if  in_ch ();
    wavhp_out_if out_ch ();
    wavhp_cfg_if cfg_ch ();

    wav_header_parser_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard limit on the length of the run.
    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // Result side: random stalls, or a counted hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (rx_hold != 0) begin
            out_ch.ready <= 1'b0;
            rx_hold--;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Every result transfer is checked at the edge where it happens.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.status, out_ch.data_size);
        end
    end

    function automatic void push_word(ref logic [7:0] fb[$], input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            fb.push_back(w[8*i +: 8]);
        end
    endfunction

    // Appends a fmt chunk that mostly matches the registers, sometimes with one flaw.
    function automatic void add_fmt_chunk(ref logic [7:0] fb[$]);
        logic [31:0] size_field;
        logic [31:0] body_len;
        logic [31:0] rate;
        logic [7:0]  tag;
        logic [7:0]  chans;
        logic [7:0]  bits;
        fmt_flaw_t   flaw;
        size_field = ($urandom_range(3) == 0) ? $urandom_range(32'(sb.max_fmt), 16) : 32'd16;
        tag   = FMT_TAG_PCM;
        chans = sb.req_channels;
        bits  = sb.req_bits;
        rate  = sb.req_rate;
        flaw  = ($urandom_range(4) == 0) ? fmt_flaw_t'($urandom_range(FLAW_RATE, FLAW_SHORT))
                                         : FLAW_NONE;
        case (flaw)
            FLAW_SHORT:    size_field = $urandom_range(15);
            FLAW_LONG:     size_field = 32'(sb.max_fmt) + $urandom_range(8, 1);
            FLAW_WRAP:     size_field = 32'hFFFF_FFFF;
            FLAW_TAG:      tag = FMT_TAG_PCM ^ 8'(1 << $urandom_range(7));
            FLAW_CHANNELS: chans ^= 8'(1 << $urandom_range(7));
            FLAW_BITS:     bits ^= 8'(1 << $urandom_range(7));
            FLAW_RATE:     rate ^= 32'd1 << $urandom_range(31);
            default: ;
        endcase
        body_len = size_field + 32'(size_field[0]);
        // Size flaws end parsing at the header, so a few trailing bytes suffice.
        if (body_len == '0 || body_len > 32'd256) begin
            body_len = 32'd4;
        end
        push_word(fb, FCC_FMT);
        push_word(fb, size_field);
        for (int unsigned i = 0; i < body_len; i++) begin
            if (i == POS_FMT_TAG) begin
                fb.push_back(tag);
            end else if (i == POS_FMT_CHAN) begin
                fb.push_back(chans);
            end else if (i >= POS_FMT_RATE0 && i <= POS_FMT_RATE3) begin
                fb.push_back(8'(rate >> (8 * (i - POS_FMT_RATE0))));
            end else if (i == POS_FMT_BITS) begin
                fb.push_back(bits);
            end else begin
                fb.push_back(8'($urandom));
            end
        end
    endfunction

    // Appends one of the skipped chunk kinds; an all-ones size pads to zero length.
    function automatic void add_skip_chunk(ref logic [7:0] fb[$]);
        logic [31:0] size_field;
        logic [31:0] body_len;
        case ($urandom_range(2))
            0: push_word(fb, FCC_DISP);
            1: push_word(fb, FCC_LIST);
            default: push_word(fb, FCC_FACT);
        endcase
        size_field = ($urandom_range(7) == 0) ? 32'hFFFF_FFFF : $urandom_range(7);
        body_len   = size_field + 32'(size_field[0]);
        push_word(fb, size_field);
        repeat (body_len) fb.push_back(8'($urandom));
    endfunction

    // Builds one file: RIFF header, a few chunks, usually a data chunk, then trailing bytes.
    function automatic void compose_file(ref logic [7:0] fb[$]);
        logic [31:0] form_id;
        logic [31:0] data_size;
        int unsigned cut;
        fb.delete();
        push_word(fb, $urandom);
        push_word(fb, $urandom);
        form_id = ($urandom_range(15) == 0) ? (FCC_WAVE ^ (32'd1 << $urandom_range(31)))
                                            : FCC_WAVE;
        push_word(fb, form_id);
        repeat ($urandom_range(3)) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: add_fmt_chunk(fb);
                5, 6, 7, 8:    add_skip_chunk(fb);
                default: begin
                    push_word(fb, $urandom);
                    push_word(fb, $urandom_range(8));
                end
            endcase
        end
        if ($urandom_range(7) != 0) begin
            case ($urandom_range(5))
                0: data_size = sb.min_data;
                1: data_size = sb.min_data - 1;
                2: data_size = sb.min_data + 1;
                3: data_size = '0;
                4: data_size = '1;
                default: data_size = $urandom;
            endcase
            push_word(fb, FCC_DATA);
            push_word(fb, data_size);
        end
        repeat ($urandom_range(3)) fb.push_back(8'($urandom));
        // Now and then the stream ends early.
        if ($urandom_range(7) == 0) begin
            cut = $urandom_range(fb.size() - 1);
            while (fb.size() > cut) void'(fb.pop_back());
        end
    endfunction

    // Offers one input item after a random gap and waits for its transfer.
    task automatic send_item(input logic [7:0] b, input logic at_end);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.stream_end <= at_end;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(b, at_end);
    endtask

    task automatic stream_file(ref logic [7:0] fb[$]);
        foreach (fb[i]) send_item(fb[i], 1'b0);
        send_item(8'($urandom), 1'b1);
    endtask

    // Stops offering, waits for every expected result, then lets the pipeline empty.
    task automatic settle();
        int unsigned waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, value);
    endtask

    // Register settings in rotation: reset values, lows, highs, typical random values.
    task automatic apply_setting(input int unsigned k);
        case (k % 4)
            1: begin
                put_reg(CFG_REQ_RATE, '0);
                put_reg(CFG_REQ_BITS, '0);
                put_reg(CFG_REQ_CHANNELS, '0);
                put_reg(CFG_MIN_DATA, '0);
                put_reg(CFG_MAX_FMT, 32'(FMT_MIN_SIZE));
                // Indexes past the last register must change nothing.
                for (int unsigned idx = int'(CFG_MAX_FMT) + 1; idx < (1 << CFG_IDX_W); idx++) begin
                    put_reg(CFG_IDX_W'(idx), $urandom);
                end
            end
            2: begin
                put_reg(CFG_REQ_RATE, '1);
                put_reg(CFG_REQ_BITS, 32'hFF);
                put_reg(CFG_REQ_CHANNELS, 32'hFF);
                put_reg(CFG_MIN_DATA, '1);
                put_reg(CFG_MAX_FMT, 32'hFF);
            end
            3: begin
                case ($urandom_range(3))
                    0: put_reg(CFG_REQ_RATE, 32'd44100);
                    1: put_reg(CFG_REQ_RATE, 32'd48000);
                    2: put_reg(CFG_REQ_RATE, 32'd22050);
                    default: put_reg(CFG_REQ_RATE, $urandom);
                endcase
                put_reg(CFG_REQ_BITS, $urandom_range(1) ? 32'd16 : 32'($urandom_range(255)));
                put_reg(CFG_REQ_CHANNELS, $urandom_range(1) ? 32'd2 : 32'($urandom_range(255)));
                put_reg(CFG_MIN_DATA, $urandom_range(4096));
                put_reg(CFG_MAX_FMT, $urandom_range(255, 16));
            end
            default: begin
                put_reg(CFG_REQ_RATE, RST_RATE);
                put_reg(CFG_REQ_BITS, 32'(RST_BITS));
                put_reg(CFG_REQ_CHANNELS, 32'(RST_CHANNELS));
                put_reg(CFG_MIN_DATA, RST_MIN_DATA);
                put_reg(CFG_MAX_FMT, 32'(RST_MAX_FMT));
            end
        endcase
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Main sequence: reset, directed streams, then random files under rotating settings.
    initial begin
        logic [7:0]  file_bytes[$];
        int unsigned base;
        int unsigned progress;
        int unsigned files;
        int unsigned setting;
        bit          pause_done;
        bit          hold_done;

        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.stream_end = 1'b0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        tx_idle_pct      = 37;
        rx_idle_pct      = 58;
        rx_hold          = 0;
        settings_used    = 1;
        files            = 0;
        setting          = 0;
        pause_done       = 1'b0;
        hold_done        = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // End of stream before any byte.
        file_bytes.delete();
        stream_file(file_bytes);
        // Early end in the middle of the RIFF header.
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        stream_file(file_bytes);
        // Wrong form id, one ignored byte after the verdict, then a silent end.
        file_bytes.delete();
        push_word(file_bytes, 32'hFFFF_FFFF);
        push_word(file_bytes, 32'h0000_0000);
        push_word(file_bytes, FCC_WAVE ^ 32'h8000_0000);
        file_bytes.push_back(8'hA5);
        stream_file(file_bytes);

        settle();
        base = sb.items_seen;
        while (sb.items_seen - base < RANDOM_ITEMS) begin
            progress = sb.items_seen - base;
            if (progress < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 37;
                rx_idle_pct = 58;
            end else if (progress < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 58;
                rx_idle_pct = 37;
                // The sender pauses once until every expected result has come.
                if (!pause_done) begin
                    pause_done = 1'b1;
                    settle();
                end
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                // Long receiver hold-off while the sender keeps offering.
                if (!hold_done) begin
                    hold_done = 1'b1;
                    rx_hold   = HOLD_CYCLES;
                end
            end
            if (files % FILES_PER_SETTING == FILES_PER_SETTING - 1) begin
                setting++;
                settle();
                apply_setting(setting);
            end
            compose_file(file_bytes);
            stream_file(file_bytes);
            files++;
        end

        settle();
        sb.flag_leftovers();
        $display("Run covered %0d stream items in %0d files, %0d verdicts, %0d settings.",
                 sb.items_seen, files + 3, sb.verdicts, settings_used);
        $display("Mismatches counted: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ wav_header_parser_top.f @@
+incdir+rtl
rtl/wavhp_pkg.sv
rtl/wavhp_channels.sv
rtl/wavhp_core.sv
rtl/wav_header_parser_top.sv
tb/tb_wav_header_parser_top.sv
